// File: rtl/clsr_pkg.sv
// package for the cubic least-squares regression fit block
// shared widths, status codes, datapath command and status structs; no dependencies
package clsr_pkg;

   localparam int NBasis   = 4;
   localparam int IdxW     = 2;
   localparam int CountW   = 13;
   localparam logic [CountW-1:0] CountMax = 13'd8191;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusNoItm    = 2'd1;
   localparam logic [1:0] StatusSingular = 2'd2;

   localparam logic [63:0] OneQ = 64'h0000_0001_0000_0000;
   localparam logic [63:0] XMax = 64'h0000_0003_FFFF_FFFF;
   localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SMin = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

   // register map indexes
   localparam logic [1:0] RegStrike   = 2'd0;
   localparam logic [1:0] RegCall     = 2'd1;
   localparam logic [1:0] RegMinPivot = 2'd2;

   // datapath operations
   typedef enum logic [3:0] {
      OpNone,
      OpAccum,     // add phi products into the sums
      OpClear,     // clear sums after a batch
      OpLoad,      // copy sums into the working matrix
      OpPivot,     // pivot search and row swap for column col
      OpElim,      // eliminate row row under column col (div + mults)
      OpBackAcc,   // accumulate m[row][col]*sol[col]
      OpBackDiv,   // sol[row] = (v-sum)/m[row][row]
      OpZeroSol
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [IdxW-1:0] row;
      logic [IdxW-1:0] col;
      logic            start;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic singular;
   } dp_stat_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      mag64 = v[63] ? (64'd0 - 64'(v)) : 64'(v);
   endfunction

   function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
      if (neg) begin
         from_mag = m[63] ? SMin : -$signed(m);
      end else begin
         from_mag = m[63] ? SMax : $signed(m);
      end
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) sat_add = a[63] ? SMin : SMax;
      else sat_add = s;
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) sat_sub = a[63] ? SMin : SMax;
      else sat_sub = s;
   endfunction

endpackage

// File: rtl/clsr_if.sv
// valid/ready channel interfaces for request and response items
// no dependencies
interface clsr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] spot_price;
   logic [31:0] discounted_cash;
   logic        last_sample;
   modport source (output valid, spot_price, discounted_cash, last_sample, input ready);
   modport sink   (input valid, spot_price, discounted_cash, last_sample, output ready);
endinterface

interface clsr_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         coef_index;
   logic signed [63:0] coef_value;
   logic [1:0]         fit_status;
   logic               last_coef;
   modport source (output valid, coef_index, coef_value, fit_status, last_coef, input ready);
   modport sink   (input valid, coef_index, coef_value, fit_status, last_coef, output ready);
endinterface

// File: rtl/cubic_least_squares_regression_fit.sv
// top level of the cubic least-squares regression fit
// an in-the-money item runs one x division (skipped for a zero strike), then 22
// products through the shared multiplier; an out-of-money item adds nothing to the sums
// a last item runs the 4x4 solve (divider bound) unless no item was in the money, then 4 result items
// reset (synchronous, active high) clears sums, count and registers to their reset values
module cubic_least_squares_regression_fit (
   input  logic        clock,
   input  logic        reset,
   clsr_req_if.sink    req,
   clsr_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [31:0] strike_ff, min_pivot_ff;
   logic        call_ff, itm;
   logic [31:0] spot_ff, cash_ff;
   clsr_pkg::dp_cmd_type  cmd;
   clsr_pkg::dp_stat_type stat;
   logic [1:0] idx;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strike_ff    <= 32'd65536;
         call_ff      <= 1'b1;
         min_pivot_ff <= 32'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            clsr_pkg::RegStrike:   strike_ff    <= csr_pwdata;
            clsr_pkg::RegCall:     call_ff      <= csr_pwdata[0];
            clsr_pkg::RegMinPivot: min_pivot_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // the accepted item is held for the whole accumulation
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         spot_ff <= req.spot_price;
         cash_ff <= req.discounted_cash;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         clsr_pkg::RegStrike:   csr_prdata = strike_ff;
         clsr_pkg::RegCall:     csr_prdata = {31'd0, call_ff};
         clsr_pkg::RegMinPivot: csr_prdata = min_pivot_ff;
         default:               csr_prdata = 32'd0;
      endcase
   end

   assign itm = call_ff ? (req.spot_price > strike_ff) : (strike_ff > req.spot_price);

   clsr_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_last(req.last_sample), .itm,
      .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_index(idx), .rsp_status(rsp.fit_status),
      .cmd, .stat
   );

   clsr_datapath u_dp (
      .clock, .reset, .cmd,
      .spot(spot_ff), .cash(cash_ff),
      .strike(strike_ff), .min_pivot(min_pivot_ff),
      .out_idx(idx), .stat, .sol_out(rsp.coef_value)
   );

   assign rsp.coef_index = idx;
   assign rsp.last_coef  = (idx == 2'd3);
endmodule

// File: rtl/clsr_mul.sv
// multi-cycle Q32.32 signed multiplier with truncation and saturation
// four 32x32 partial products, one per cycle; depends on clsr_pkg
module clsr_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic               done,
   output logic signed [63:0] y
);
   logic [63:0]  ua_ff, ub_ff;
   logic         neg_ff;
   logic [2:0]   step_ff;
   logic         run_ff;
   logic [127:0] acc_ff;
   logic [63:0]  prod;
   logic [127:0] term;

   always_comb begin
      prod = 64'd0;
      term = 128'd0;
      case (step_ff[1:0])
         2'd0: begin
            prod = 64'(ua_ff[31:0]) * 64'(ub_ff[31:0]);
            term = 128'(prod);
         end
         2'd1: begin
            prod = 64'(ua_ff[31:0]) * 64'(ub_ff[63:32]);
            term = 128'(prod) << 32;
         end
         2'd2: begin
            prod = 64'(ua_ff[63:32]) * 64'(ub_ff[31:0]);
            term = 128'(prod) << 32;
         end
         default: begin
            prod = 64'(ua_ff[63:32]) * 64'(ub_ff[63:32]);
            term = 128'(prod) << 64;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      done <= 1'b0;
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= 3'd0;
      end else if (start) begin
         ua_ff   <= clsr_pkg::mag64(a);
         ub_ff   <= clsr_pkg::mag64(b);
         neg_ff  <= a[63] ^ b[63];
         acc_ff  <= 128'd0;
         step_ff <= 3'd0;
         run_ff  <= 1'b1;
      end else if (run_ff) begin
         acc_ff  <= acc_ff + term;
         step_ff <= step_ff + 3'd1;
         if (step_ff == 3'd3) begin
            run_ff <= 1'b0;
            done   <= 1'b1;
         end
      end
   end

   always_comb begin
      if (acc_ff[127:96] != 32'd0) y = neg_ff ? clsr_pkg::SMin : clsr_pkg::SMax;
      else y = clsr_pkg::from_mag(acc_ff[95:32], neg_ff);
   end
endmodule

// File: rtl/clsr_div.sv
// restoring divider, one quotient bit a cycle, Q32.32 quotient with saturation
// also used unsigned for x = spot/strike; depends on clsr_pkg
module clsr_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [63:0]        num_mag,
   input  logic [63:0]        den_mag,
   input  logic               neg,
   input  logic               unsigned_out,
   output logic               done,
   output logic signed [63:0] y
);
   logic [63:0] rem_ff, lo_ff, q_ff, den_ff;
   logic [6:0]  cnt_ff;
   logic        run_ff, neg_ff, uns_ff, ovf_ff;
   logic [63:0] rem_sh;
   logic        carry;

   assign carry  = rem_ff[63];
   assign rem_sh = {rem_ff[62:0], lo_ff[63]};

   always_ff @(posedge clock) begin
      done <= 1'b0;
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= 7'd0;
      end else if (start) begin
         rem_ff <= {32'd0, num_mag[63:32]};
         lo_ff  <= {num_mag[31:0], 32'd0};
         den_ff <= den_mag;
         q_ff   <= 64'd0;
         neg_ff <= neg;
         uns_ff <= unsigned_out;
         ovf_ff <= ({32'd0, num_mag[63:32]} >= den_mag);
         cnt_ff <= 7'd0;
         run_ff <= 1'b1;
      end else if (run_ff) begin
         lo_ff <= {lo_ff[62:0], 1'b0};
         if (carry || rem_sh >= den_ff) begin
            rem_ff <= rem_sh - den_ff;
            q_ff   <= {q_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            q_ff   <= {q_ff[62:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_ff <= 1'b0;
            done   <= 1'b1;
         end
      end
   end

   always_comb begin
      if (uns_ff) y = $signed(ovf_ff ? 64'hFFFF_FFFF_FFFF_FFFF : q_ff);
      else if (ovf_ff) y = neg_ff ? clsr_pkg::SMin : clsr_pkg::SMax;
      else y = clsr_pkg::from_mag(q_ff, neg_ff);
   end
endmodule

// File: rtl/clsr_datapath.sv
// datapath: normal-equation sums, working matrix, shared multiplier and divider
// driven by clsr_ctrl through dp_cmd_type; depends on clsr_pkg, clsr_mul, clsr_div
module clsr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  clsr_pkg::dp_cmd_type cmd,
   input  logic [31:0]          spot,
   input  logic [31:0]          cash,
   input  logic [31:0]          strike,
   input  logic [31:0]          min_pivot,
   input  logic [1:0]           out_idx,
   output clsr_pkg::dp_stat_type stat,
   output logic signed [63:0]   sol_out
);
   logic signed [63:0] sum_ff [16];
   logic signed [63:0] rhs_ff [4];
   logic signed [63:0] m_ff   [16];
   logic signed [63:0] v_ff   [4];
   logic signed [63:0] sol_ff [4];
   logic signed [63:0] phi_ff [4];
   logic signed [63:0] f_ff, acc_ff;
   logic [4:0]         seq_ff;     // sub-step within an operation
   logic               busy_ff, sing_ff;
   clsr_pkg::op_type   op_ff;
   logic [1:0]         row_ff, col_ff;
   logic [2:0]         c_ff;       // column walk inside elimination
   logic [4:0]         k_ff;       // product index inside accumulation

   logic               mul_start, mul_done, div_start, div_done;
   logic signed [63:0] mul_a, mul_b, mul_y, div_y;
   logic [63:0]        div_n, div_d;
   logic               div_neg, div_uns;

   clsr_mul u_mul (.clock, .reset, .start(mul_start), .a(mul_a), .b(mul_b),
                   .done(mul_done), .y(mul_y));
   clsr_div u_div (.clock, .reset, .start(div_start), .num_mag(div_n), .den_mag(div_d),
                   .neg(div_neg), .unsigned_out(div_uns), .done(div_done), .y(div_y));

   // pivot search over one column, combinational over at most four rows
   logic [1:0]  piv;
   logic [63:0] best;
   always_comb begin
      piv  = col_ff;
      best = clsr_pkg::mag64(m_ff[{col_ff, col_ff}]);
      for (int r = 1; r < clsr_pkg::NBasis; r++) begin
         if (2'(r) > col_ff && clsr_pkg::mag64(m_ff[{2'(r), col_ff}]) > best) begin
            best = clsr_pkg::mag64(m_ff[{2'(r), col_ff}]);
            piv  = 2'(r);
         end
      end
   end

   // multiplier operand selection by op and sub-step
   always_comb begin
      mul_a = 64'sd0;
      mul_b = 64'sd0;
      case (op_ff)
         clsr_pkg::OpAccum: begin
            if (k_ff == 5'd0) begin
               mul_a = phi_ff[1]; mul_b = phi_ff[1];
            end else if (k_ff == 5'd1) begin
               mul_a = phi_ff[2]; mul_b = phi_ff[1];
            end else if (k_ff < 5'd18) begin
               mul_a = phi_ff[2'((k_ff - 5'd2) >> 2)];
               mul_b = phi_ff[2'(k_ff - 5'd2)];
            end else begin
               mul_a = phi_ff[2'(k_ff - 5'd18)];
               mul_b = $signed({16'd0, cash, 16'd0});
            end
         end
         clsr_pkg::OpElim: begin
            mul_a = f_ff;
            mul_b = (c_ff == 3'd4) ? v_ff[col_ff] : m_ff[{col_ff, c_ff[1:0]}];
         end
         clsr_pkg::OpBackAcc: begin
            mul_a = m_ff[{row_ff, col_ff}];
            mul_b = sol_ff[col_ff];
         end
         default: ;
      endcase
   end

   always_comb begin
      div_n   = clsr_pkg::mag64(m_ff[{row_ff, col_ff}]);
      div_d   = clsr_pkg::mag64(m_ff[{col_ff, col_ff}]);
      div_neg = m_ff[{row_ff, col_ff}][63] ^ m_ff[{col_ff, col_ff}][63];
      div_uns = 1'b0;
      if (op_ff == clsr_pkg::OpAccum) begin
         div_n   = {32'd0, spot};
         div_d   = {32'd0, strike};
         div_neg = 1'b0;
         div_uns = 1'b1;
      end else if (op_ff == clsr_pkg::OpBackDiv) begin
         div_n   = clsr_pkg::mag64(clsr_pkg::sat_sub(v_ff[row_ff], acc_ff));
         div_d   = clsr_pkg::mag64(m_ff[{row_ff, row_ff}]);
         div_neg = clsr_pkg::sat_sub(v_ff[row_ff], acc_ff) < 0
                   ? ~m_ff[{row_ff, row_ff}][63] : m_ff[{row_ff, row_ff}][63];
      end
   end

   assign mul_start = busy_ff && seq_ff == 5'd1 && (op_ff == clsr_pkg::OpAccum ?
                      k_ff != 5'd22 : op_ff == clsr_pkg::OpElim || op_ff == clsr_pkg::OpBackAcc);
   assign div_start = busy_ff && seq_ff == 5'd0 && (op_ff == clsr_pkg::OpAccum
                      ? strike != 32'd0 : op_ff == clsr_pkg::OpElim && c_ff == 3'd7
                      || op_ff == clsr_pkg::OpBackDiv);

   assign stat.busy     = busy_ff;
   assign stat.singular = sing_ff;
   assign sol_out       = sol_ff[out_idx];

   logic signed [63:0] xq;
   assign xq = (strike == 32'd0) ? $signed(clsr_pkg::XMax)
             : ($unsigned(div_y) > clsr_pkg::XMax ? $signed(clsr_pkg::XMax) : div_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sing_ff <= 1'b0;
         op_ff   <= clsr_pkg::OpNone;
         seq_ff  <= 5'd0;
         for (int i = 0; i < 16; i++) sum_ff[i] <= 64'sd0;
         for (int i = 0; i < 4; i++) rhs_ff[i] <= 64'sd0;
      end else if (cmd.start) begin
         op_ff   <= cmd.op;
         row_ff  <= cmd.row;
         col_ff  <= cmd.col;
         seq_ff  <= 5'd0;
         c_ff    <= 3'd7;
         k_ff    <= 5'd0;
         // the back-substitution sum runs on into the division of its row
         acc_ff  <= (cmd.op == clsr_pkg::OpBackAcc || cmd.op == clsr_pkg::OpBackDiv)
                    ? acc_ff : 64'sd0;
         busy_ff <= 1'b1;
         if (cmd.op == clsr_pkg::OpNone) busy_ff <= 1'b0;
         if (strike == 32'd0 && cmd.op == clsr_pkg::OpAccum) seq_ff <= 5'd2;
      end else if (busy_ff) begin
         case (op_ff)
            clsr_pkg::OpClear: begin
               for (int i = 0; i < 16; i++) sum_ff[i] <= 64'sd0;
               for (int i = 0; i < 4; i++) rhs_ff[i] <= 64'sd0;
               sing_ff <= 1'b0;
               busy_ff <= 1'b0;
            end
            clsr_pkg::OpZeroSol: begin
               for (int i = 0; i < 4; i++) sol_ff[i] <= 64'sd0;
               busy_ff <= 1'b0;
            end
            clsr_pkg::OpLoad: begin
               for (int i = 0; i < 16; i++) m_ff[i] <= sum_ff[i];
               for (int i = 0; i < 4; i++) v_ff[i] <= rhs_ff[i];
               acc_ff  <= 64'sd0;
               busy_ff <= 1'b0;
            end
            clsr_pkg::OpPivot: begin
               if (piv != col_ff) begin
                  for (int c = 0; c < 4; c++) begin
                     m_ff[{col_ff, 2'(c)}] <= m_ff[{piv, 2'(c)}];
                     m_ff[{piv, 2'(c)}]    <= m_ff[{col_ff, 2'(c)}];
                  end
                  v_ff[col_ff] <= v_ff[piv];
                  v_ff[piv]    <= v_ff[col_ff];
               end
               if (best == 64'd0 || best < {32'd0, min_pivot}) sing_ff <= 1'b1;
               busy_ff <= 1'b0;
            end
            clsr_pkg::OpAccum: begin
               // seq 0: divider start; seq 3: wait x, set phi0/phi1; seq 2 (zero strike): phi1 = XMax; then 22 products
               if (seq_ff == 5'd0) seq_ff <= 5'd3;
               else if (seq_ff == 5'd3) begin
                  if (div_done) begin
                     phi_ff[0] <= $signed(clsr_pkg::OneQ);
                     phi_ff[1] <= xq;
                     seq_ff    <= 5'd1;
                  end
               end else if (seq_ff == 5'd2) begin
                  phi_ff[0] <= $signed(clsr_pkg::OneQ);
                  phi_ff[1] <= $signed(clsr_pkg::XMax);
                  seq_ff    <= 5'd1;
               end else if (seq_ff == 5'd1) begin
                  if (k_ff == 5'd22) begin
                     busy_ff <= 1'b0;
                  end else seq_ff <= 5'd4;
               end else if (mul_done) begin
                  if (k_ff == 5'd0) phi_ff[2] <= mul_y;
                  else if (k_ff == 5'd1) phi_ff[3] <= mul_y;
                  else if (k_ff < 5'd18)
                     sum_ff[4'(k_ff - 5'd2)] <= clsr_pkg::sat_add(sum_ff[4'(k_ff - 5'd2)], mul_y);
                  else
                     rhs_ff[2'(k_ff - 5'd18)] <= clsr_pkg::sat_add(rhs_ff[2'(k_ff - 5'd18)], mul_y);
                  k_ff   <= k_ff + 5'd1;
                  seq_ff <= 5'd1;
               end
            end
            clsr_pkg::OpElim: begin
               if (c_ff == 3'd7) begin
                  if (seq_ff == 5'd0) seq_ff <= 5'd4;
                  else if (div_done) begin
                     f_ff   <= div_y;
                     c_ff   <= {1'b0, col_ff};
                     seq_ff <= 5'd1;
                  end
               end else if (seq_ff == 5'd1) seq_ff <= 5'd4;
               else if (mul_done) begin
                  if (c_ff == 3'd4) begin
                     v_ff[row_ff] <= clsr_pkg::sat_sub(v_ff[row_ff], mul_y);
                     busy_ff      <= 1'b0;
                  end else begin
                     m_ff[{row_ff, c_ff[1:0]}] <=
                        clsr_pkg::sat_sub(m_ff[{row_ff, c_ff[1:0]}], mul_y);
                  end
                  c_ff   <= c_ff + 3'd1;
                  seq_ff <= 5'd1;
               end
            end
            clsr_pkg::OpBackAcc: begin
               if (seq_ff == 5'd0) seq_ff <= 5'd1;
               else if (seq_ff == 5'd1) seq_ff <= 5'd4;
               else if (mul_done) begin
                  acc_ff  <= clsr_pkg::sat_add(acc_ff, mul_y);
                  busy_ff <= 1'b0;
               end
            end
            clsr_pkg::OpBackDiv: begin
               if (seq_ff == 5'd0) seq_ff <= 5'd4;
               else if (div_done) begin
                  sol_ff[row_ff] <= div_y;
                  acc_ff         <= 64'sd0;
                  busy_ff        <= 1'b0;
               end
            end
            default: busy_ff <= 1'b0;
         endcase
      end
   end
endmodule

// File: rtl/clsr_ctrl.sv
// controller: intake, solve sequence and coefficient output
// commands clsr_datapath; depends on clsr_pkg
module clsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   input  logic                  itm,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_index,
   output logic [1:0]            rsp_status,
   output clsr_pkg::dp_cmd_type  cmd,
   input  clsr_pkg::dp_stat_type stat
);
   typedef enum logic [3:0] {
      SIdle, SAccWait, SSolveLoad, SPivot, SPivotWait, SElim, SElimWait,
      SBack, SBackWait, SBackDiv, SZero, SOut, SClear, SClearWait
   } state_type;

   state_type                   state_ff;
   logic [1:0]                  i_ff, r_ff, j_ff, k_ff;
   logic                        last_ff;
   logic [clsr_pkg::CountW-1:0] cnt_ff;
   logic [1:0]                  status_ff;

   assign req_ready  = (state_ff == SIdle);
   assign rsp_valid  = (state_ff == SOut);
   assign rsp_index  = k_ff;
   assign rsp_status = status_ff;

   always_ff @(posedge clock) begin
      cmd.start <= 1'b0;
      if (reset) begin
         state_ff  <= SIdle;
         cnt_ff    <= '0;
         status_ff <= clsr_pkg::StatusOk;
         cmd.op    <= clsr_pkg::OpNone;
         cmd.row   <= 2'd0;
         cmd.col   <= 2'd0;
         k_ff      <= 2'd0;
      end else begin
         case (state_ff)
            SIdle: if (req_valid) begin
               last_ff <= req_last;
               if (itm) begin
                  if (cnt_ff != clsr_pkg::CountMax) cnt_ff <= cnt_ff + 1'b1;
                  cmd.op    <= clsr_pkg::OpAccum;
                  cmd.start <= 1'b1;
                  state_ff  <= SAccWait;
               end else if (req_last) state_ff <= SSolveLoad;
            end
            SAccWait: if (!cmd.start && !stat.busy)
               state_ff <= last_ff ? SSolveLoad : SIdle;
            SSolveLoad: begin
               if (cnt_ff == '0) begin
                  status_ff <= clsr_pkg::StatusNoItm;
                  state_ff  <= SZero;
               end else begin
                  status_ff <= clsr_pkg::StatusOk;
                  cmd.op    <= clsr_pkg::OpLoad;
                  cmd.start <= 1'b1;
                  i_ff      <= 2'd0;
                  state_ff  <= SPivot;
               end
            end
            SPivot: if (!cmd.start && !stat.busy) begin
               cmd.op    <= clsr_pkg::OpPivot;
               cmd.col   <= i_ff;
               cmd.start <= 1'b1;
               r_ff      <= i_ff + 2'd1;
               state_ff  <= SPivotWait;
            end
            SPivotWait: if (!cmd.start && !stat.busy) begin
               if (stat.singular) begin
                  status_ff <= clsr_pkg::StatusSingular;
                  state_ff  <= SZero;
               end else if (i_ff == 2'd3) begin
                  r_ff     <= 2'd3;
                  j_ff     <= 2'd3;
                  state_ff <= SBackDiv;
               end else state_ff <= SElim;
            end
            SElim: begin
               cmd.op    <= clsr_pkg::OpElim;
               cmd.row   <= r_ff;
               cmd.col   <= i_ff;
               cmd.start <= 1'b1;
               state_ff  <= SElimWait;
            end
            SElimWait: if (!cmd.start && !stat.busy) begin
               if (r_ff == 2'd3) begin
                  i_ff     <= i_ff + 2'd1;
                  state_ff <= SPivot;
               end else begin
                  r_ff     <= r_ff + 2'd1;
                  state_ff <= SElim;
               end
            end
            SBack: begin
               cmd.op    <= clsr_pkg::OpBackAcc;
               cmd.row   <= r_ff;
               cmd.col   <= j_ff;
               cmd.start <= 1'b1;
               state_ff  <= SBackWait;
            end
            SBackWait: if (!cmd.start && !stat.busy) begin
               if (j_ff == 2'd3) state_ff <= SBackDiv;
               else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= SBack;
               end
            end
            SBackDiv: if (!cmd.start && !stat.busy) begin
               if (cmd.op == clsr_pkg::OpBackDiv) begin
                  if (r_ff == 2'd0) begin
                     k_ff     <= 2'd0;
                     state_ff <= SOut;
                  end else begin
                     r_ff     <= r_ff - 2'd1;
                     j_ff     <= r_ff;
                     state_ff <= SBack;
                  end
                  cmd.op <= clsr_pkg::OpNone;
               end else begin
                  cmd.op    <= clsr_pkg::OpBackDiv;
                  cmd.row   <= r_ff;
                  cmd.col   <= r_ff;
                  cmd.start <= 1'b1;
               end
            end
            SZero: begin
               cmd.op    <= clsr_pkg::OpZeroSol;
               cmd.start <= 1'b1;
               k_ff      <= 2'd0;
               state_ff  <= SClearWait;
            end
            SClearWait: if (!cmd.start && !stat.busy) state_ff <= SOut;
            SOut: if (rsp_ready) begin
               if (k_ff == 2'd3) begin
                  cmd.op    <= clsr_pkg::OpClear;
                  cmd.start <= 1'b1;
                  cnt_ff    <= '0;
                  state_ff  <= SClear;
               end else k_ff <= k_ff + 2'd1;
            end
            SClear: if (!cmd.start && !stat.busy) state_ff <= SIdle;
            default: state_ff <= SIdle;
         endcase
      end
   end
endmodule

// File: sim/clsr_checker.sv
// checker for the cubic least-squares regression fit: watches both channels,
// predicts the coefficient items and compares them; depends on clsr_pkg
`timescale 1ns / 1ps
module clsr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_spot_price,
   input  logic [31:0] req_discounted_cash,
   input  logic        req_last_sample,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_coef_index,
   input  logic [63:0] rsp_coef_value,
   input  logic [1:0]  rsp_fit_status,
   input  logic        rsp_last_coef,
   input  logic        cfg_we,
   input  logic [1:0]  cfg_idx,
   input  logic [31:0] cfg_val,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic [1:0]  idx;
      logic [63:0] value;
      logic [1:0]  status;
      logic        last;
   } coef_item_type;

   coef_item_type coef_q[$];

   logic [31:0] strike_r;
   logic        call_r;
   logic [31:0] min_pivot_r;
   logic signed [63:0] sum_m [16];
   logic signed [63:0] sum_v [4];
   logic signed [63:0] sol [4];
   int unsigned itm_count;

   assign pending = coef_q.size();

   function automatic logic [63:0] absv(input logic signed [63:0] v);
      return v[63] ? 64'd0 - v : v;
   endfunction

   function automatic logic signed [63:0] sgn_from(input logic [63:0] m, input logic neg);
      if (neg) return m[63] ? clsr_pkg::SMin : -$signed(m);
      return m[63] ? clsr_pkg::SMax : $signed(m);
   endfunction

   function automatic logic signed [63:0] add_s(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? clsr_pkg::SMin : clsr_pkg::SMax;
      return s;
   endfunction

   function automatic logic signed [63:0] sub_s(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) return a[63] ? clsr_pkg::SMin : clsr_pkg::SMax;
      return s;
   endfunction

   function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic [127:0] p;
      p = {64'd0, absv(a)} * {64'd0, absv(b)};
      if (p[127:96] != 0) return (a[63] ^ b[63]) ? clsr_pkg::SMin : clsr_pkg::SMax;
      return sgn_from(p[95:32], a[63] ^ b[63]);
   endfunction

   function automatic logic signed [63:0] qdiv(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic [127:0] n;
      logic [127:0] q;
      n = {32'd0, absv(a), 32'd0};
      if (absv(a) >> 32 >= absv(b)) return (a[63] ^ b[63]) ? clsr_pkg::SMin : clsr_pkg::SMax;
      q = n / {64'd0, absv(b)};
      return sgn_from(q[63:0], a[63] ^ b[63]);
   endfunction

   function automatic logic [1:0] solve_fit();
      logic signed [63:0] m [4][4];
      logic signed [63:0] v [4];
      logic signed [63:0] t, f, acc;
      logic [63:0] best;
      int piv;
      for (int i = 0; i < 4; i++) begin
         for (int c = 0; c < 4; c++) m[i][c] = sum_m[i*4+c];
         v[i] = sum_v[i];
      end
      for (int i = 0; i < clsr_pkg::NBasis; i++) begin
         piv = i;
         best = absv(m[i][i]);
         for (int r = i + 1; r < clsr_pkg::NBasis; r++) begin
            if (absv(m[r][i]) > best) begin
               best = absv(m[r][i]);
               piv = r;
            end
         end
         if (piv != i) begin
            for (int c = 0; c < 4; c++) begin
               t = m[i][c]; m[i][c] = m[piv][c]; m[piv][c] = t;
            end
            t = v[i]; v[i] = v[piv]; v[piv] = t;
         end
         if (best == 0 || best < {32'd0, min_pivot_r}) return clsr_pkg::StatusSingular;
         for (int r = i + 1; r < clsr_pkg::NBasis; r++) begin
            f = qdiv(m[r][i], m[i][i]);
            for (int c = i; c < clsr_pkg::NBasis; c++)
               m[r][c] = sub_s(m[r][c], qmul(f, m[i][c]));
            v[r] = sub_s(v[r], qmul(f, v[i]));
         end
      end
      for (int i = clsr_pkg::NBasis - 1; i >= 0; i--) begin
         acc = 0;
         for (int j = i + 1; j < clsr_pkg::NBasis; j++) acc = add_s(acc, qmul(m[i][j], sol[j]));
         sol[i] = qdiv(sub_s(v[i], acc), m[i][i]);
      end
      return clsr_pkg::StatusOk;
   endfunction

   task automatic take_sample(input logic [31:0] spot, input logic [31:0] cash,
                              input logic last);
      logic itm;
      logic [63:0] xu;
      logic signed [63:0] phi [4];
      logic signed [63:0] y;
      logic [1:0] st;
      coef_item_type it;
      itm = call_r ? (spot > strike_r) : (strike_r > spot);
      if (itm) begin
         xu = (strike_r == 0) ? clsr_pkg::XMax : ({spot, 32'd0} / {32'd0, strike_r});
         if (xu > clsr_pkg::XMax) xu = clsr_pkg::XMax;
         phi[0] = clsr_pkg::OneQ;
         phi[1] = xu;
         phi[2] = qmul(phi[1], phi[1]);
         phi[3] = qmul(phi[2], phi[1]);
         y = {16'd0, cash, 16'd0};
         for (int r = 0; r < clsr_pkg::NBasis; r++) begin
            for (int c = 0; c < clsr_pkg::NBasis; c++)
               sum_m[r*4+c] = add_s(sum_m[r*4+c], qmul(phi[r], phi[c]));
            sum_v[r] = add_s(sum_v[r], qmul(phi[r], y));
         end
         if (itm_count < clsr_pkg::CountMax) itm_count++;
      end
      if (last) begin
         st = (itm_count == 0) ? clsr_pkg::StatusNoItm : solve_fit();
         if (st != clsr_pkg::StatusOk) for (int k = 0; k < 4; k++) sol[k] = 0;
         for (int k = 0; k < clsr_pkg::NBasis; k++) begin
            it.idx = k[1:0];
            it.value = sol[k];
            it.status = st;
            it.last = (k == clsr_pkg::NBasis - 1);
            coef_q = {coef_q, it};
         end
         for (int k = 0; k < 16; k++) sum_m[k] = 0;
         for (int k = 0; k < 4; k++) sum_v[k] = 0;
         itm_count = 0;
      end
   endtask

   always @(posedge clock) begin
      coef_item_type want;
      if (reset) begin
         strike_r <= 32'd65536;
         call_r <= 1'b1;
         min_pivot_r <= 32'd1;
         for (int k = 0; k < 16; k++) sum_m[k] = 0;
         for (int k = 0; k < 4; k++) begin
            sum_v[k] = 0;
            sol[k] = 0;
         end
         itm_count = 0;
         fail_count <= 0;
         coef_q.delete();
      end else begin
         if (cfg_we) begin
            case (cfg_idx)
               clsr_pkg::RegStrike:   strike_r <= cfg_val;
               clsr_pkg::RegCall:     call_r <= cfg_val[0];
               clsr_pkg::RegMinPivot: min_pivot_r <= cfg_val;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            take_sample(req_spot_price, req_discounted_cash, req_last_sample);
         if (rsp_valid && rsp_ready) begin
            if (coef_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected coefficient item idx %0d", rsp_coef_index);
            end else begin
               want = coef_q.pop_front();
               if (want.idx !== rsp_coef_index || want.value !== rsp_coef_value ||
                   want.status !== rsp_fit_status || want.last !== rsp_last_coef) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch exp idx %0d val %h st %0d last %0d, got %0d %h %0d %0d",
                              want.idx, want.value, want.status, want.last, rsp_coef_index,
                              rsp_coef_value, rsp_fit_status, rsp_last_coef);
               end
            end
         end
      end
   end
endmodule

// File: sim/cubic_least_squares_regression_fit_tb.sv
// testbench top for the cubic least-squares regression fit: drives samples and
// register writes, hands checking to clsr_checker; depends on clsr_pkg, clsr_if, the RTL
`timescale 1ns / 1ps
module cubic_least_squares_regression_fit_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        cfg_we;
   int          fail_count, pending;
   longint      cycles = 0;
   logic [31:0] strike_now = 32'd65536;

   clsr_req_if req ();
   clsr_rsp_if rsp ();

   always #6 clock = ~clock;

   cubic_least_squares_regression_fit u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   assign cfg_we = csr_psel && csr_penable && csr_pwrite && csr_pready;

   clsr_checker u_check (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_spot_price(req.spot_price),
      .req_discounted_cash(req.discounted_cash), .req_last_sample(req.last_sample),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_coef_index(rsp.coef_index),
      .rsp_coef_value(rsp.coef_value), .rsp_fit_status(rsp.fit_status),
      .rsp_last_coef(rsp.last_coef), .cfg_we(cfg_we), .cfg_idx(csr_paddr[3:2]),
      .cfg_val(csr_pwdata), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      req.valid = 1'b0;
      req.spot_price = '0;
      req.discounted_cash = '0;
      req.last_sample = 1'b0;
      rsp.ready = 1'b0;
   end

   // watchdog sized for ~210 items plus solves and stalls
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side stalls at random
   initial begin
      int w;
      @(posedge clock iff !reset);
      forever begin
         w = $urandom_range(0, 5);
         if (w != 0) begin
            rsp.ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock iff rsp.valid);
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock iff csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
      if (idx == clsr_pkg::RegStrike) strike_now = val;
   endtask

   // valid stays high between items sent with no gap
   task automatic send_sample(input logic [31:0] spot, input logic [31:0] cash,
                              input logic last);
      int w;
      w = $urandom_range(0, 5);
      if (w != 0) begin
         req.valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.spot_price <= spot;
      req.discounted_cash <= cash;
      req.last_sample <= last;
      @(posedge clock iff req.ready);
   endtask

   task automatic wait_empty();
      req.valid <= 1'b0;
      @(posedge clock iff pending == 0);
   endtask

   task automatic drain();
      wait_empty();
      repeat (1200) @(posedge clock);
   endtask

   // spot near strike so x stays small and the fit stays well conditioned
   function automatic logic [31:0] near_spot();
      logic [63:0] s;
      s = strike_now * $urandom_range(1, 60) / 20 + $urandom_range(0, 255);
      return (s > 64'hFFFF_FFFF) ? $urandom : s[31:0];
   endfunction

   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: no in-the-money, then extremes of the fields
      send_sample(32'd0, 32'hFFFF_FFFF, 1'b1);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0002_0000, 32'h0001_0000, 1'b0);
      send_sample(32'h0003_0000, 32'h0000_0000, 1'b1);
      // singular: one point only
      send_sample(32'h0002_0000, 32'h0005_0000, 1'b1);
      // good fit, min_pivot zero
      drain();
      csr_write(clsr_pkg::RegMinPivot, 32'd0);
      for (int k = 0; k < 6; k++) send_sample(32'h0001_8000 + k * 32'h0000_9000,
                                                $urandom, k == 5);
      drain();
      // put with zero strike: never in the money
      csr_write(clsr_pkg::RegCall, 32'd0);
      csr_write(clsr_pkg::RegStrike, 32'd0);
      send_sample(32'd0, 32'h1234_5678, 1'b0);
      send_sample(32'd5, 32'h1234_5678, 1'b1);
      drain();
      // call with zero strike: x saturates
      csr_write(clsr_pkg::RegCall, 32'd1);
      send_sample(32'd1, 32'hAAAA_5555, 1'b0);
      send_sample(32'h5555_AAAA, 32'd7, 1'b1);
      drain();
      csr_write(clsr_pkg::RegStrike, 32'hFFFF_FFFF);
      csr_write(clsr_pkg::RegCall, 32'd0);
      csr_write(clsr_pkg::RegMinPivot, 32'hFFFF_FFFF);
      for (int k = 0; k < 5; k++) send_sample($urandom, $urandom, k == 4);
      drain();
      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(clsr_pkg::RegStrike,
                   (ph % 3 == 0) ? 32'h0001_0000 : $urandom_range(1, 32'h00FF_FFFF));
         csr_write(clsr_pkg::RegCall, ph % 2);
         csr_write(clsr_pkg::RegMinPivot, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(0, 16));
         for (int b = 0; b < 7; b++) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 9) == 0)
                  send_sample($urandom, $urandom, k == n - 1);
               else
                  send_sample(near_spot(), $urandom, k == n - 1);
            end
            if (b == 3) wait_empty();
         end
         drain();
      end
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/clsr_pkg.sv
rtl/clsr_if.sv
rtl/clsr_mul.sv
rtl/clsr_div.sv
rtl/clsr_datapath.sv
rtl/clsr_ctrl.sv
rtl/cubic_least_squares_regression_fit.sv
sim/clsr_checker.sv
sim/cubic_least_squares_regression_fit_tb.sv
